// ----- rtl/vdit_pkg.sv -----
// Shared types and constants for the vertex deduplication index table.
// Used by the lookup cell and the top level; depends on nothing else.
package vdit_pkg;

   // Default configuration of the table.
   localparam int TableDepthDefault = 64;
   localparam int IndexBitsDefault  = 16;

   // Widths of the fixed stream fields.
   localparam int FieldBits   = 16;
   localparam int ElementBits = 6;

   // Control that travels with a corner from cell to cell.
   typedef struct packed {
      logic valid;   // a corner occupies this stage
      logic clear;   // the corner opens a new mesh
      logic done;    // a slot has been found or allocated
      logic added;   // the slot was allocated for this corner
   } token_ctl_type;

endpackage

// ----- rtl/vertex_dedup_index_table.sv -----
// Top level of the vertex deduplication index table: a chain of lookup cells
// and the result register. Depends on vdit_pkg and vdit_cell.
//
//  Channel | Direction | tdata (low bit up)                  | tuser (low bit up)
//  req_    | in        | pos_index, uv_index, normal_index    | start_mesh
//  rsp_    | out       | element_index, 2 zero bits           | was_added, table_overflow
//
// Each corner walks the chain one cell per cycle while the chain advances,
// passing through every cell register of the chain and then the result
// register; a new corner enters every cycle unless the chain holds.
// Reset empties the table and drops every corner in flight.
// When a result waits and rsp_tready is low, the whole chain holds.
module vertex_dedup_index_table #(
   parameter int TABLE_DEPTH = vdit_pkg::TableDepthDefault,
   parameter int INDEX_BITS  = vdit_pkg::IndexBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_index, uv_index, normal_index
   input  logic [0:0]  req_tuser,   // start_mesh
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // element_index, two zero bits
   output logic [1:0]  rsp_tuser    // was_added, table_overflow
);

   localparam int FB        = vdit_pkg::FieldBits;
   localparam int EB        = vdit_pkg::ElementBits;
   localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
   localparam int WIDE_BITS = (SLOT_BITS > EB) ? SLOT_BITS : EB;
   localparam int KEY_BITS  = 3 * INDEX_BITS;

   vdit_pkg::token_ctl_type  chain_ctl  [TABLE_DEPTH+1];
   logic [KEY_BITS-1:0]      chain_key  [TABLE_DEPTH+1];
   logic [SLOT_BITS-1:0]     chain_slot [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0]   cell_valid;
   logic                     advance;
   logic                     rsp_valid_ff;
   logic [EB-1:0]            element_ff;
   logic                     added_ff;
   logic                     overflow_ff;
   logic [WIDE_BITS-1:0]     slot_wide;

   // The chain moves whenever the result register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Corner entering the chain, each index cut or widened to INDEX_BITS.
   assign chain_ctl[0]  = '{valid: req_tvalid, clear: req_tuser[0],
                            done: 1'b0, added: 1'b0};
   assign chain_key[0]  = {INDEX_BITS'(req_tdata[3*FB-1:2*FB]),
                           INDEX_BITS'(req_tdata[2*FB-1:FB]),
                           INDEX_BITS'(req_tdata[FB-1:0])};
   assign chain_slot[0] = '0;

   // One cell per table slot.
   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      vdit_cell #(
         .INDEX_BITS (INDEX_BITS),
         .SLOT_BITS  (SLOT_BITS),
         .SLOT       (gi)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .up_ctl      (chain_ctl[gi]),
         .up_key      (chain_key[gi]),
         .up_slot     (chain_slot[gi]),
         .dn_ctl      (chain_ctl[gi+1]),
         .dn_key      (chain_key[gi+1]),
         .dn_slot     (chain_slot[gi+1]),
         .entry_valid (cell_valid[gi])
      );
   end

   assign slot_wide = WIDE_BITS'(chain_slot[TABLE_DEPTH]);

   // Result register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_ctl[TABLE_DEPTH].valid;
      end
   end

   // Result payload; a corner that found no slot reports overflow at slot 0.
   always_ff @(posedge clock) begin
      if (advance) begin
         element_ff  <= chain_ctl[TABLE_DEPTH].done ? slot_wide[EB-1:0] : '0;
         added_ff    <= chain_ctl[TABLE_DEPTH].added;
         overflow_ff <= !chain_ctl[TABLE_DEPTH].done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, element_ff};
   assign rsp_tuser  = {overflow_ff, added_ff};

   // Once any entry is held, slot 0 is held; a mesh restart refills it first.
   a_slot0_kept : assert property (@(posedge clock) disable iff (reset)
      (cell_valid == '0) || cell_valid[0])
      else $error("an entry is held while slot 0 is empty");

   // An overflow never reports an allocation and always answers slot 0.
   a_overflow_result : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata[EB-1:0] == '0)
      else $error("overflow result carries a slot or an allocation");

   // A result that is held off stays offered and unchanged.
   a_result_held : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held result changed or was dropped");

   // Nothing is offered in the cycle after reset.
   a_quiet_after_reset : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

// ----- rtl/vdit_cell.sv -----
// One cell of the lookup chain: holds a single table entry and its valid bit.
// Depends on vdit_pkg for the token control struct.
module vdit_cell #(
   parameter int INDEX_BITS = vdit_pkg::IndexBitsDefault,
   parameter int SLOT_BITS  = 6,
   parameter int SLOT       = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  vdit_pkg::token_ctl_type   up_ctl,
   input  logic [3*INDEX_BITS-1:0]   up_key,
   input  logic [SLOT_BITS-1:0]      up_slot,
   output vdit_pkg::token_ctl_type   dn_ctl,
   output logic [3*INDEX_BITS-1:0]   dn_key,
   output logic [SLOT_BITS-1:0]      dn_slot,
   output logic                      entry_valid
);

   localparam logic [SLOT_BITS-1:0] MySlot = SLOT_BITS'(SLOT);

   logic                      valid_ff;
   logic                      valid_in;
   logic [3*INDEX_BITS-1:0]   entry_ff;
   vdit_pkg::token_ctl_type   ctl_ff;
   vdit_pkg::token_ctl_type   ctl_in;
   logic [3*INDEX_BITS-1:0]   key_ff;
   logic [SLOT_BITS-1:0]      slot_ff;
   logic [SLOT_BITS-1:0]      slot_in;
   logic                      live;
   logic                      seen_valid;
   logic                      hit;
   logic                      take;

   // A corner that opens a mesh invalidates the entry before it is compared.
   // Entries fill from the bottom, so the first empty cell a pending corner
   // meets is the next free slot.
   always_comb begin
      live       = up_ctl.valid && !up_ctl.done;
      seen_valid = valid_ff && !(up_ctl.valid && up_ctl.clear);
      hit        = live && seen_valid && (entry_ff == up_key);
      take       = live && !seen_valid;
      valid_in   = seen_valid || take;
      ctl_in       = up_ctl;
      ctl_in.done  = up_ctl.done || hit || take;
      ctl_in.added = up_ctl.added || take;
      slot_in      = (hit || take) ? MySlot : up_slot;
   end

   // Entry state of the cell and the stage it hands on; only the valid bits
   // are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         if (take) begin
            entry_ff <= up_key;
         end
         ctl_ff.clear <= ctl_in.clear;
         ctl_ff.done  <= ctl_in.done;
         ctl_ff.added <= ctl_in.added;
         key_ff       <= up_key;
         slot_ff      <= slot_in;
      end
   end

   assign dn_ctl      = ctl_ff;
   assign dn_key      = key_ff;
   assign dn_slot     = slot_ff;
   assign entry_valid = valid_ff;

endmodule

// ----- test/vertex_dedup_index_table_tb.sv -----
// Self-checking testbench for the vertex deduplication index table.
// It streams face corners in, predicts each slot answer with its own copy of
// the table, and checks every result. Depends on vdit_pkg and the RTL top.
module vertex_dedup_index_table_tb;

   localparam int Depth         = vdit_pkg::TableDepthDefault;
   localparam int EB            = vdit_pkg::ElementBits;
   localparam int FB            = vdit_pkg::FieldBits;
   localparam int HoldCycles    = 400;
   localparam int WatchdogLimit = 3000;
   localparam int DrainCycles   = Depth + 20;

   // Expected answer for one corner.
   typedef struct packed {
      logic [EB-1:0] element_index;
      logic          was_added;
      logic          table_overflow;
   } slot_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // pos_index, uv_index, normal_index
   logic [0:0]  req_tuser = '0;   // start_mesh
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // element_index, two zero bits
   logic [1:0]  rsp_tuser;        // was_added, table_overflow

   // Predicted table contents and the answers still to come back.
   logic [47:0]     known_triples [0:Depth-1];
   int              known_count = 0;
   slot_answer_type pending_answers_q[$];
   slot_answer_type oldest_answer;

   int   error_count = 0;
   int   quiet_cycles = 0;
   logic sender_idle_on = 1'b1;
   logic receiver_idle_on = 1'b1;
   logic hold_request = 1'b0;

   vertex_dedup_index_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock generation.
   initial begin
      forever #10 clock = ~clock;
   end

   // Looks the triple up in the predicted table, appending it when it is new.
   function automatic slot_answer_type lookup_or_append(input logic start,
                                                        input logic [47:0] triple);
      slot_answer_type answer;
      answer = '0;
      if (start) known_count = 0;
      for (int i = 0; i < known_count; i++) begin
         if (known_triples[i] == triple) begin
            answer.element_index = i[EB-1:0];
            return answer;
         end
      end
      if (known_count < Depth) begin
         known_triples[known_count] = triple;
         answer.element_index = known_count[EB-1:0];
         answer.was_added = 1'b1;
         known_count++;
      end else begin
         answer.table_overflow = 1'b1;
      end
      return answer;
   endfunction

   function automatic logic [47:0] pack_triple(input logic [FB-1:0] pos,
                                               input logic [FB-1:0] uv,
                                               input logic [FB-1:0] nrm);
      return {nrm, uv, pos};
   endfunction

   // Offers one corner, waits for its transaction and records the prediction.
   task automatic send_corner(input logic start, input logic [47:0] triple);
      slot_answer_type answer;
      while (sender_idle_on && $urandom_range(99, 0) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= triple;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answer = lookup_or_append(start, triple);
      pending_answers_q = {pending_answers_q, answer};
   endtask

   // Field extremes, exact repeats and mesh restarts.
   task automatic test_extremes();
      send_corner(1'b1, pack_triple(16'h0000, 16'h0000, 16'h0000));
      send_corner(1'b0, pack_triple(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_corner(1'b0, pack_triple(16'hFFFF, 16'h0000, 16'h0000));
      send_corner(1'b0, pack_triple(16'h0000, 16'hFFFF, 16'h0000));
      send_corner(1'b0, pack_triple(16'h0000, 16'h0000, 16'hFFFF));
      send_corner(1'b0, pack_triple(16'h0000, 16'h0000, 16'h0000));
      send_corner(1'b0, pack_triple(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_corner(1'b0, pack_triple(16'hAAAA, 16'h5555, 16'hAAAA));
      send_corner(1'b0, pack_triple(16'h5555, 16'hAAAA, 16'h5555));
      send_corner(1'b0, pack_triple(16'h0000, 16'hFFFF, 16'h0000));
      send_corner(1'b1, pack_triple(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_corner(1'b0, pack_triple(16'h0000, 16'h0000, 16'h0000));
      send_corner(1'b0, pack_triple(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_corner(1'b1, pack_triple(16'h0001, 16'h0001, 16'h0001));
   endtask

   // Fills the table, offers new and stored triples against a full table, then restarts the mesh.
   task automatic test_overflow();
      logic [FB-1:0] base;
      base = 16'($urandom);
      for (int i = 0; i < Depth; i++)
         send_corner(i == 0, pack_triple(base + 16'(i), 16'(i), 16'hFFFF - 16'(i)));
      send_corner(1'b0, pack_triple(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_corner(1'b0, pack_triple(base + 16'(Depth - 1), 16'(Depth - 1),
                                    16'hFFFF - 16'(Depth - 1)));
      send_corner(1'b0, pack_triple(base, 16'h0000, 16'hFFFF));
      send_corner(1'b0, pack_triple(base, 16'h0001, 16'hFFFF));
      send_corner(1'b1, pack_triple(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_corner(1'b0, pack_triple(base, 16'h0000, 16'hFFFF));
   endtask

   // Random meshes drawn from small triple pools so that repeats are common.
   // Pool entries often differ from an earlier one in a single field.
   task automatic test_random_meshes(input int item_target);
      logic [47:0] pool[$];
      logic [47:0] triple;
      int sent;
      int mesh_no;
      int pool_size;
      int mesh_len;
      sent = 0;
      mesh_no = 0;
      while (sent < item_target) begin
         // A stretch of meshes runs with both sides always ready.
         sender_idle_on   = !(mesh_no >= 1 && mesh_no < 3);
         receiver_idle_on = sender_idle_on;
         pool.delete();
         pool_size = ($urandom_range(99, 0) < 80) ? $urandom_range(40, 1)
                                                  : $urandom_range(100, 50);
         for (int i = 0; i < pool_size; i++) begin
            triple = 48'({$urandom, $urandom});
            if (i > 0 && $urandom_range(2, 0) == 0) begin
               triple = pool[$urandom_range(i - 1, 0)];
               case ($urandom_range(2, 0))
                  0: triple[15:0]  = 16'($urandom);
                  1: triple[31:16] = 16'($urandom);
                  default: triple[47:32] = 16'($urandom);
               endcase
            end
            pool = {pool, triple};
         end
         mesh_len = $urandom_range(120, 1);
         for (int i = 0; i < mesh_len; i++) begin
            if ($urandom_range(99, 0) < 5)
               triple = 48'({$urandom, $urandom});
            else
               triple = pool[$urandom_range(pool_size - 1, 0)];
            send_corner(i == 0 || $urandom_range(99, 0) < 3, triple);
            sent++;
         end
         mesh_no++;
      end
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while corners keep coming.
   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 150; i++)
         send_corner(i == 0, pack_triple(16'($urandom_range(7, 0)),
                                         16'($urandom_range(3, 0)), 16'h0000));
      sender_idle_on = 1'b1;
   endtask

   // Stimulus sequence and end of run.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_overflow();
      test_random_meshes(340);
      test_backpressure();
      req_tvalid <= 1'b0;
      while (pending_answers_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (receiver_idle_on && $urandom_range(99, 0) < 9) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compares each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual index %0d tuser %b",
                     $time, rsp_tdata[EB-1:0], rsp_tuser);
         end else begin
            oldest_answer = pending_answers_q.pop_front();
            if (rsp_tdata[EB-1:0] != oldest_answer.element_index) begin
               error_count++;
               $display("%0t: element_index mismatch: expected %0d, actual %0d",
                        $time, oldest_answer.element_index, rsp_tdata[EB-1:0]);
            end
            if (rsp_tuser[0] != oldest_answer.was_added) begin
               error_count++;
               $display("%0t: was_added mismatch: expected %b, actual %b",
                        $time, oldest_answer.was_added, rsp_tuser[0]);
            end
            if (rsp_tuser[1] != oldest_answer.table_overflow) begin
               error_count++;
               $display("%0t: table_overflow mismatch: expected %b, actual %b",
                        $time, oldest_answer.table_overflow, rsp_tuser[1]);
            end
         end
      end
   end

   // Ends the run when no transaction happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- vertex_dedup_index_table.f -----
rtl/vdit_pkg.sv
rtl/vdit_cell.sv
rtl/vertex_dedup_index_table.sv
test/vertex_dedup_index_table_tb.sv
